FILE: hdl/transitive_closure_connectivity_core_defines.svh
// Assertion macros for the transitive closure core checker.
// No dependencies; included by the checker file only.
`ifndef TRANSITIVE_CLOSURE_CONNECTIVITY_CORE_DEFINES_SVH
`define TRANSITIVE_CLOSURE_CONNECTIVITY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcc_pkg.sv
// Shared types, constants and helper functions for the transitive closure core.
// No dependencies; imported by every module of the block.
package tcc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ROW_SLOTS    = 32;
  localparam int VLIMIT       = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
  localparam int ROW_W        = 32;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 6;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic load_last;
    logic prep;
    logic pivot;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic out_free;
  } status_t;

  function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] vc);
    logic [CNT_W-1:0] n;
    n = vc;
    if (vc == '0) begin
      n = CNT_W'(1);
    end else if (vc > CNT_W'(VLIMIT)) begin
      n = CNT_W'(VLIMIT);
    end
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] row_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

endpackage

FILE: hdl/transitive_closure_connectivity_core.sv
// Top level of the Warshall transitive closure core on a bit matrix.
// Depends on tcc_pkg, tcc_ctrl and tcc_dpath.
//
//   channel | dir | ports                 | beat contents
//   in      | in  | in_t{valid,ready,...} | tdata: row_bits[31:0]; tlast: last_row
//   out     | out | out_t{valid,ready,..} | tdata: row_index, closure_row; tuser, tlast
//   cfg     | in  | cfg_wr_en, cfg_wr_data| vertex_count
//
// Row beats are accepted back to back while loading; the last row is followed
// by a prepare step, a sweep over the n pivots (all rows updated per pivot) and
// an emit sweep of n result beats, one per row.
// Input is held off (in_tready low) from the last row until the final result
// is loaded into the output register. Output stalls hold the emit sweep.
// Synchronous active-low reset; vertex_count resets to 32.
module transitive_closure_connectivity_core import tcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,   // vertex_count
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // row_bits[31:0]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // row_index[4:0], closure_row[36:5], zero
  output logic                   out_tuser,     // all_connected
  output logic                   out_tlast
);

  cmd_t    cmd;
  status_t status;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tcc_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_row      (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

FILE: hdl/tcc_ctrl.sv
// Controller state machine: load, prepare, pivot sweep and emit phases.
// Depends on tcc_pkg; drives commands into tcc_dpath.
module tcc_ctrl import tcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load      = 1'b1;
          cmd.load_last = in_tlast;
          if (in_tlast) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        cmd.pivot = 1'b1;
        if (status.last_idx) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_idx) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

FILE: hdl/tcc_dpath.sv
// Datapath: vertex count register, row registers, load counter, pivot/emit
// index and output register. Depends on tcc_pkg; commanded by tcc_ctrl.
module tcc_dpath import tcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,
  input  logic [ROW_W-1:0]       in_row,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [CNT_W-1:0]       vc_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       n_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   all_one_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;
  logic                   out_last_r;
  logic [ROW_W-1:0]       rows_r [ROW_SLOTS];

  logic [CNT_W-1:0] cur_n;
  logic [ROW_W-1:0] cur_mask;
  logic [ROW_W-1:0] mask_n;
  logic [CNT_W-1:0] n_m1;
  logic [ROW_W-1:0] sel_row;
  logic             store_en;
  logic             row_full;

  assign cur_n    = active_count(vc_r);
  assign cur_mask = row_mask(cur_n);
  assign mask_n   = row_mask(n_r);
  assign n_m1     = n_r - CNT_W'(1);
  assign sel_row  = rows_r[idx_r];
  assign store_en = (cnt_r < cur_n);
  assign row_full = (sel_row == mask_n);

  assign status.last_idx = (idx_r == n_m1[IDX_W-1:0]);
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= CNT_W'(VLIMIT);
      cnt_r       <= '0;
      n_r         <= CNT_W'(1);
      idx_r       <= '0;
      all_one_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vc_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (cmd.load_last) begin
          n_r <= cur_n;
        end
      end
      if (cmd.prep) begin
        idx_r     <= '0;
        all_one_r <= 1'b1;
      end
      if (cmd.pivot) begin
        idx_r <= status.last_idx ? '0 : idx_r + IDX_W'(1);
      end
      if (cmd.emit) begin
        all_one_r   <= all_one_r & row_full;
        out_valid_r <= 1'b1;
        if (status.last_idx) begin
          idx_r <= '0;
          cnt_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {{(OUT_TDATA_W - ROW_W - IDX_W){1'b0}}, sel_row, idx_r};
      out_user_r <= status.last_idx & all_one_r & row_full;
      out_last_r <= status.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_en) begin
      rows_r[cnt_r[IDX_W-1:0]] <= in_row & cur_mask;
    end else if (cmd.prep) begin
      for (int i = 0; i < ROW_SLOTS; i++) begin
        if (CNT_W'(i) < n_r) begin
          rows_r[i] <= (CNT_W'(i) < cnt_r) ? (rows_r[i] & mask_n) : '0;
        end
      end
    end else if (cmd.pivot) begin
      for (int i = 0; i < ROW_SLOTS; i++) begin
        if ((CNT_W'(i) < n_r) && rows_r[i][idx_r]) begin
          rows_r[i] <= rows_r[i] | sel_row;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/tcc_checker.sv
// Port-level checker for the transitive closure core, bound to the top level.
// Depends on tcc_pkg and transitive_closure_connectivity_core_defines.svh.
`include "transitive_closure_connectivity_core_defines.svh"

module tcc_checker import tcc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  logic out_wait;
  logic last_in;

  assign out_wait = out_tvalid && !out_tready;
  assign last_in  = in_tvalid && in_tready && in_tlast;

  `TCC_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_tdata), "stalled beat changed")
  `TCC_ASSERT_NOW(a_flag_on_last, out_tvalid && out_tuser, out_tlast, "flag off last beat")
  `TCC_ASSERT_NEXT(a_busy_after_last, last_in, !in_tready, "input taken after last row")
  `TCC_ASSERT_NOW(a_no_load_mid_run, out_tvalid && !out_tlast, !in_tready, "input open mid run")

endmodule

bind transitive_closure_connectivity_core tcc_checker u_tcc_checker (.*);
